[rtl/w2e_pkg.sv]
// ----------------------------------------------------------------------------
// w2e_pkg: shared constants for the 802.11 to ethernet header rewrite
// offsets and lengths of the 802.11 mac header fields, register indexes
// ----------------------------------------------------------------------------
package w2e_pkg;

    // mac header lengths
    localparam logic [5:0] HDR_LEN_3ADDR = 6'd24;
    localparam logic [5:0] HDR_LEN_4ADDR = 6'd30;
    localparam logic [5:0] QOS_LEN       = 6'd2;
    localparam logic [5:0] LLC_SNAP_LEN  = 6'd6;

    // address field offsets
    localparam logic [5:0] ADDR1_OFS     = 6'd4;
    localparam logic [5:0] ADDR2_OFS     = 6'd10;
    localparam logic [5:0] ADDR3_OFS     = 6'd16;
    localparam logic [5:0] ADDR4_OFS     = 6'd24;
    localparam logic [5:0] MAC_LEN       = 6'd6;

    // address store: da in entries 0..5, sa in entries 6..11
    localparam int unsigned ADDR_BYTES   = 12;
    localparam logic [3:0]  SA_BASE      = 4'd6;
    localparam logic [3:0]  LAST_ADDR    = 4'd11;

    // frame control fields
    localparam logic [3:0] SUBTYPE_QOS   = 4'h8;
    localparam logic [1:0] DS_BOTH       = 2'd3;
    localparam logic [1:0] DS_FROM       = 2'd2;

    // register indexes
    localparam logic [1:0] REG_TRANSLATE_ENABLE = 2'd0;

endpackage

[rtl/wifi_to_ethernet_header_rewrite.sv]
// ----------------------------------------------------------------------------
// wifi_to_ethernet_header_rewrite: 802.11 data frame to ethernet ii frame
// drops the mac header, qos control and llc/snap bytes, emits da, sa, payload
// ----------------------------------------------------------------------------
// output: registered; the first result byte of an accepted byte is valid in the cycle after it is accepted
// throughput: one byte per cycle while the output does not stall; the first
//   payload byte (or the final llc byte of a frame with no payload) starts a
//   burst of the 12 address bytes from the store, then that payload byte if
//   any, and input is held off until the burst is through
// reset: synchronous active low; position, mode flags and output valid clear,
//   translate_enable returns to 1; the address store is not cleared
// ----------------------------------------------------------------------------
module wifi_to_ethernet_header_rewrite #(
    parameter int unsigned MAX_FRAME_LEN = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last

    // output byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // out_last
    output logic        m_axis_tuser,   // [0] frame_short

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_LEN);

    typedef enum logic [1:0] {
        ST_IDLE,    // one result or none per accepted byte
        ST_ADDR,    // streaming address bytes out of the store
        ST_TAIL     // first payload byte after the addresses
    } t_state;

    t_state           r_state;
    logic [3:0]       r_burst_idx;
    logic             r_tail_pending;
    logic             r_hdr_only;
    logic [7:0]       r_tail_byte;
    logic             r_tail_last;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_short;

    logic [POS_W-1:0] r_pos;
    logic [1:0]       r_ds_mode;
    logic             r_qos;
    logic             r_enable;
    logic [7:0]       r_addr [w2e_pkg::ADDR_BYTES];

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    logic out_free;
    logic in_acc;
    logic cfg_wr;

    assign out_free      = !r_out_valid || m_axis_tready;
    // a new request waits while an address burst is still going out
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready &&
                           (paddr[3:2] == w2e_pkg::REG_TRANSLATE_ENABLE);
    assign prdata        = (paddr[3:2] == w2e_pkg::REG_TRANSLATE_ENABLE) ?
                           {31'd0, r_enable} : 32'd0;

    // ------------------------------------------------------------------------
    // header tracking for the byte at the input
    // ------------------------------------------------------------------------
    logic       pos_small;      // position fits the 6-bit header window
    logic [5:0] pos_lo;
    logic       n_qos;
    logic [1:0] n_ds_mode;
    logic [5:0] hdr_len;
    logic [5:0] da_ofs;
    logic [5:0] sa_ofs;
    logic [5:0] da_rel;
    logic [5:0] sa_rel;
    logic       cap_we;
    logic [3:0] cap_idx;
    logic       in_header;
    logic       at_payload;
    logic       at_final_llc;

    assign pos_small = (r_pos[POS_W-1:6] == '0);
    assign pos_lo    = r_pos[5:0];

    always_comb begin
        n_qos     = r_qos;
        n_ds_mode = r_ds_mode;
        if (r_pos == '0) begin
            n_qos = (s_axis_tdata[7:4] == w2e_pkg::SUBTYPE_QOS);
        end else if (r_pos == POS_W'(1)) begin
            n_ds_mode = s_axis_tdata[1:0];
        end
    end

    // header length uses the flags as updated by this byte
    assign hdr_len = ((n_ds_mode == w2e_pkg::DS_BOTH) ? w2e_pkg::HDR_LEN_4ADDR
                                                      : w2e_pkg::HDR_LEN_3ADDR)
                   + (n_qos ? w2e_pkg::QOS_LEN : 6'd0)
                   + w2e_pkg::LLC_SNAP_LEN;

    // tods selects addr3 as da; sa is addr2, addr3 or addr4
    assign da_ofs = r_ds_mode[0] ? w2e_pkg::ADDR3_OFS : w2e_pkg::ADDR1_OFS;
    always_comb begin
        case (r_ds_mode)
            w2e_pkg::DS_BOTH: sa_ofs = w2e_pkg::ADDR4_OFS;
            w2e_pkg::DS_FROM: sa_ofs = w2e_pkg::ADDR3_OFS;
            default:          sa_ofs = w2e_pkg::ADDR2_OFS;
        endcase
    end

    assign da_rel = pos_lo - da_ofs;
    assign sa_rel = pos_lo - sa_ofs;

    // da and sa windows never overlap, so one write per byte
    always_comb begin
        cap_we  = 1'b0;
        cap_idx = 4'd0;
        if (pos_small && (r_pos > POS_W'(1))) begin
            if ((pos_lo >= da_ofs) && (da_rel < w2e_pkg::MAC_LEN)) begin
                cap_we  = 1'b1;
                cap_idx = da_rel[3:0];
            end else if ((pos_lo >= sa_ofs) && (sa_rel < w2e_pkg::MAC_LEN)) begin
                cap_we  = 1'b1;
                cap_idx = w2e_pkg::SA_BASE + sa_rel[3:0];
            end
        end
    end

    assign in_header    = pos_small && (pos_lo < hdr_len);
    assign at_payload   = pos_small && (pos_lo == hdr_len);
    assign at_final_llc = pos_small && ((pos_lo + 6'd1) == hdr_len);

    // ------------------------------------------------------------------------
    // address store, written by header bytes only
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && cap_we) begin
            r_addr[cap_idx] <= s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------------
    // frame tracking and configuration
    // ------------------------------------------------------------------------
    logic [POS_W-1:0] n_pos;

    always_comb begin
        if (s_axis_tlast) begin
            n_pos = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_ds_mode <= 2'd0;
            r_qos     <= 1'b0;
            r_enable  <= 1'b1;
        end else begin
            if (cfg_wr) begin
                r_enable <= pwdata[0];
            end
            if (in_acc) begin
                r_pos     <= n_pos;
                r_ds_mode <= n_ds_mode;
                r_qos     <= n_qos;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sequencing and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            case (r_state)
                ST_IDLE: begin
                    r_out_valid <= 1'b0;
                    if (in_acc) begin
                        if (!r_enable || !in_header && !at_payload) begin
                            // passthrough or later payload byte
                            r_out_valid <= 1'b1;
                            r_out_byte  <= s_axis_tdata;
                            r_out_last  <= s_axis_tlast;
                            r_out_short <= 1'b0;
                        end else if (at_payload || (s_axis_tlast && at_final_llc)) begin
                            // address burst, da[0] goes out now
                            r_out_valid    <= 1'b1;
                            r_out_byte     <= r_addr[0];
                            r_out_last     <= 1'b0;
                            r_out_short    <= 1'b0;
                            r_burst_idx    <= 4'd1;
                            r_tail_pending <= at_payload;
                            r_hdr_only     <= !at_payload;
                            r_tail_byte    <= s_axis_tdata;
                            r_tail_last    <= s_axis_tlast;
                            r_state        <= ST_ADDR;
                        end else if (s_axis_tlast) begin
                            // frame ended inside the header
                            r_out_valid <= 1'b1;
                            r_out_byte  <= 8'd0;
                            r_out_last  <= 1'b1;
                            r_out_short <= 1'b1;
                        end
                    end
                end
                ST_ADDR: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= r_addr[r_burst_idx];
                    r_out_last  <= (r_burst_idx == w2e_pkg::LAST_ADDR) && r_hdr_only;
                    r_out_short <= 1'b0;
                    if (r_burst_idx == w2e_pkg::LAST_ADDR) begin
                        r_state <= r_tail_pending ? ST_TAIL : ST_IDLE;
                    end else begin
                        r_burst_idx <= r_burst_idx + 4'd1;
                    end
                end
                ST_TAIL: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= r_tail_byte;
                    r_out_last  <= r_tail_last;
                    r_out_short <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_short;

endmodule
